// ----- rtl/ps2kr_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2kr_pkg
// Shared constants and types for the PS/2 keyboard scan-code receiver.
// ----------------------------------------------------------------------------
package ps2kr_pkg;

    localparam logic [7:0]  PREFIX_EXT    = 8'hE0;
    localparam logic [7:0]  PREFIX_BREAK  = 8'hF0;
    localparam logic [7:0]  DATA_MSB      = 8'h80;
    localparam logic [3:0]  FRAME_STEPS   = 4'd11;
    localparam logic [3:0]  LAST_DATA_CNT = 4'd2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef enum logic
    {
        OP_EDGE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed
    {
        logic       byte_done;
        logic [7:0] scan_byte;
        logic       key_event;
        logic       extended;
        logic       idle_timeout;
    } result_t;

endpackage

// ----- rtl/ps2_keyboard_receiver_top.sv -----
// ----------------------------------------------------------------------------
// ps2_keyboard_receiver_top
// PS/2 keyboard scan-code receiver: frames bits, tracks E0/F0 prefixes and
// flags key events and keyboard inactivity.
// ----------------------------------------------------------------------------
// Each input beat is one falling keyboard clock edge or one timer tick. The
// block takes one beat per cycle while the result register can load and gives
// exactly one result beat for it, held in a single result register; a new
// beat is taken while the previous result is being taken, so the sustained
// rate is one beat per cycle when the sink keeps ready high. timeout_reg is
// written through cfg_we/cfg_wdata and resets to 100.
module ps2_keyboard_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic        data_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_done,
    output logic [7:0]  scan_byte,
    output logic        key_event,
    output logic        extended,
    output logic        idle_timeout
);

    logic               accept;
    logic               can_load;
    ps2kr_pkg::result_t step_result;
    ps2kr_pkg::result_t held;

    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    ps2kr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (accept),
        .op        (op),
        .data_bit  (data_bit),
        .result    (step_result)
    );

    ps2kr_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .data      (held)
    );

    assign byte_done    = held.byte_done;
    assign scan_byte    = held.scan_byte;
    assign key_event    = held.key_event;
    assign extended     = held.extended;
    assign idle_timeout = held.idle_timeout;

endmodule

// ----- rtl/ps2kr_core.sv -----
// ----------------------------------------------------------------------------
// ps2kr_core
// Frame counter, shift register, prefix tracking and inactivity timer.
// Works one beat per cycle and produces its result in the same cycle.
// ----------------------------------------------------------------------------
module ps2kr_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                step,
    input  logic                op,
    input  logic                data_bit,
    output ps2kr_pkg::result_t  result
);

    logic [15:0] timeout_reg;
    logic [3:0]  bits_left_reg,  bits_left_next;
    logic [7:0]  shift_reg,      shift_next;
    logic [7:0]  cur_reg,        cur_next;
    logic [7:0]  prev_reg,       prev_next;
    logic        ext_flag_reg,   ext_flag_next;
    logic [15:0] idle_reg,       idle_next;

    logic [3:0]  bits_dec;
    logic [15:0] idle_inc;
    logic        key;

    always_comb
    begin
        bits_left_next = bits_left_reg;
        shift_next     = shift_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        ext_flag_next  = ext_flag_reg;
        idle_next      = idle_reg;
        key            = 1'b0;
        bits_dec       = bits_left_reg - 4'd1;
        idle_inc       = idle_reg + 16'd1;
        result         = '0;

        if (ps2kr_pkg::op_t'(op) == ps2kr_pkg::OP_EDGE)
        begin
            idle_next = '0;
            // shift only the eight data bits of the frame
            if (bits_left_reg < ps2kr_pkg::FRAME_STEPS
                && bits_left_reg > ps2kr_pkg::LAST_DATA_CNT)
            begin
                shift_next = {data_bit, shift_reg[7:1]};
            end
            bits_left_next = bits_dec;
            if (bits_dec == 4'd0)
            begin
                bits_left_next   = ps2kr_pkg::FRAME_STEPS;
                prev_next        = cur_reg;
                cur_next         = shift_next;
                result.byte_done = 1'b1;
                if (shift_next == ps2kr_pkg::PREFIX_EXT)
                begin
                    ext_flag_next = 1'b1;
                end
                else if (shift_next == ps2kr_pkg::PREFIX_BREAK
                         && cur_reg == ps2kr_pkg::PREFIX_EXT)
                begin
                    ext_flag_next = 1'b0;
                end
                else if (cur_reg == ps2kr_pkg::PREFIX_EXT)
                begin
                    ext_flag_next = 1'b1;
                    key           = 1'b1;
                end
                else if (cur_reg != ps2kr_pkg::PREFIX_BREAK
                         && shift_next != ps2kr_pkg::PREFIX_BREAK)
                begin
                    ext_flag_next = 1'b0;
                    key           = 1'b1;
                end
                result.key_event = key;
                result.extended  = key & ext_flag_next;
            end
        end
        else
        begin
            // tick: drop any partial frame, advance the idle count
            bits_left_next = ps2kr_pkg::FRAME_STEPS;
            idle_next      = idle_inc;
            if (idle_inc >= timeout_reg)
            begin
                result.idle_timeout = 1'b1;
                idle_next           = '0;
            end
        end
        result.scan_byte = cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= ps2kr_pkg::TIMEOUT_RESET;
            bits_left_reg <= ps2kr_pkg::FRAME_STEPS;
            shift_reg     <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            ext_flag_reg  <= 1'b0;
            idle_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (step)
            begin
                bits_left_reg <= bits_left_next;
                shift_reg     <= shift_next;
                cur_reg       <= cur_next;
                prev_reg      <= prev_next;
                ext_flag_reg  <= ext_flag_next;
                idle_reg      <= idle_next;
            end
        end
    end

endmodule

// ----- rtl/ps2kr_out_reg.sv -----
// ----------------------------------------------------------------------------
// ps2kr_out_reg
// Result register with valid/ready handshake; takes a new beat whenever it is
// empty or the held one is taken in the same cycle.
// ----------------------------------------------------------------------------
module ps2kr_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ps2kr_pkg::result_t  load_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                can_load,
    output ps2kr_pkg::result_t  data
);

    logic               valid_reg, valid_next;
    ps2kr_pkg::result_t data_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the PS/2 keyboard scan-code receiver. A scoreboard predicts
// one result per accepted edge or tick: the framing, the byte, the prefix
// tracking, the key event and the inactivity pulse. Each result is compared
// field by field. Stimulus is a short directed part, then random key
// sequences, noise and tick bursts under several timeouts and idling mixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUIET_LIMIT    = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_SLACK    = 3;

    class keyboard_scoreboard;
        logic [15:0]         timeout_limit;
        logic [3:0]          frame_count;
        logic [7:0]          shift_reg;
        logic [7:0]          cur_byte;
        logic [7:0]          prev_byte;
        logic                ext_flag;
        logic [15:0]         idle_count;
        ps2kr_pkg::result_t  expected_q[$];
        int                  mismatches;

        function void reset_state();
            timeout_limit = ps2kr_pkg::TIMEOUT_RESET;
            frame_count   = ps2kr_pkg::FRAME_STEPS;
            shift_reg     = '0;
            cur_byte      = '0;
            prev_byte     = '0;
            ext_flag      = 1'b0;
            idle_count    = '0;
            expected_q.delete();
            mismatches    = 0;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout_limit = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(ps2kr_pkg::op_t kind, logic bit_val);
            ps2kr_pkg::result_t r;
            r = '0;
            if (kind == ps2kr_pkg::OP_EDGE)
            begin
                idle_count = '0;
                // shift only the eight data bits; start, parity and stop pass by
                if (frame_count < ps2kr_pkg::FRAME_STEPS
                    && frame_count > ps2kr_pkg::LAST_DATA_CNT)
                    shift_reg = {bit_val, shift_reg[7:1]};
                frame_count = frame_count - 4'd1;
                if (frame_count == 4'd0)
                begin
                    frame_count = ps2kr_pkg::FRAME_STEPS;
                    prev_byte   = cur_byte;
                    cur_byte    = shift_reg;
                    r.byte_done = 1'b1;
                    if (cur_byte == ps2kr_pkg::PREFIX_EXT)
                        ext_flag = 1'b1;
                    else if (cur_byte == ps2kr_pkg::PREFIX_BREAK
                             && prev_byte == ps2kr_pkg::PREFIX_EXT)
                        ext_flag = 1'b0;
                    else if (prev_byte == ps2kr_pkg::PREFIX_EXT)
                    begin
                        ext_flag    = 1'b1;
                        r.key_event = 1'b1;
                    end
                    else if (prev_byte != ps2kr_pkg::PREFIX_BREAK
                             && cur_byte != ps2kr_pkg::PREFIX_BREAK)
                    begin
                        ext_flag    = 1'b0;
                        r.key_event = 1'b1;
                    end
                    r.extended = r.key_event & ext_flag;
                end
            end
            else
            begin
                idle_count = idle_count + 16'd1;
                if (idle_count >= timeout_limit)
                begin
                    r.idle_timeout = 1'b1;
                    idle_count     = '0;
                end
                // re-arm the frame; a partial byte is dropped
                frame_count = ps2kr_pkg::FRAME_STEPS;
            end
            r.scan_byte = cur_byte;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(ps2kr_pkg::result_t seen);
            ps2kr_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result beat 0x%0h with nothing expected", seen);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("byte_done", 8'(want.byte_done), 8'(seen.byte_done));
            compare_field("scan_byte", want.scan_byte, seen.scan_byte);
            compare_field("key_event", 8'(want.key_event), 8'(seen.key_event));
            compare_field("extended", 8'(want.extended), 8'(seen.extended));
            compare_field("idle_timeout", 8'(want.idle_timeout),
                          8'(seen.idle_timeout));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic        data_bit;
    logic        out_valid;
    logic        out_ready;
    logic        byte_done;
    logic [7:0]  scan_byte;
    logic        key_event;
    logic        extended;
    logic        idle_timeout;

    keyboard_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int cur_timeout;
    int quiet_cycles;
    bit holdoff_request;

    ps2_keyboard_receiver_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .data_bit     (data_bit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_done    (byte_done),
        .scan_byte    (scan_byte),
        .key_event    (key_event),
        .extended     (extended),
        .idle_timeout (idle_timeout)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                out_ready = 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_request = 1'b0;
            end
            out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(ps2kr_pkg::result_t'({byte_done, scan_byte, key_event,
                                                  extended, idle_timeout}));
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // offer one beat and hold it until taken; valid stays high on return
    task automatic send_item(input ps2kr_pkg::op_t kind, input logic bit_val);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op       = kind;
        data_bit = bit_val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(kind, bit_val);
        items_sent++;
    endtask

    // clean: start, eight data bits LSB first, odd parity, stop; else start, parity and stop are random
    task automatic send_frame(input logic [7:0] value, input bit clean);
        logic [10:0] bits;
        bits = {1'b1, ~^value, value, 1'b0};
        if (!clean)
            bits = {2'($urandom_range(0, 3)), value, 1'($urandom_range(0, 1))};
        for (int i = 0; i < 11; i++)
            send_item(ps2kr_pkg::OP_EDGE, bits[i]);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_timeout(value);
        cur_timeout = int'(value);
    endtask

    function automatic logic [7:0] pick_key();
        logic [7:0] k;
        k = 8'($urandom_range(0, 255));
        while (k == ps2kr_pkg::PREFIX_EXT || k == ps2kr_pkg::PREFIX_BREAK)
            k = 8'($urandom_range(0, 255));
        return k;
    endfunction

    task automatic send_random_sequence();
        int pick;
        int count;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_frame(pick_key(), 1'b1);
        else if (pick < 45)
        begin
            send_frame(ps2kr_pkg::PREFIX_EXT, 1'b1);
            send_frame(pick_key(), 1'b1);
        end
        else if (pick < 60)
        begin
            send_frame(ps2kr_pkg::PREFIX_BREAK, 1'b1);
            send_frame(pick_key(), 1'b1);
        end
        else if (pick < 70)
        begin
            send_frame(ps2kr_pkg::PREFIX_EXT, 1'b1);
            send_frame(ps2kr_pkg::PREFIX_BREAK, 1'b1);
            send_frame(pick_key(), 1'b1);
        end
        else if (pick < 78)
            send_frame(8'($urandom_range(0, 255)), 1'b0);
        else if (pick < 88)
        begin
            count = $urandom_range(1, cur_timeout + 3);
            repeat (count) send_item(ps2kr_pkg::OP_TICK, 1'($urandom_range(0, 1)));
        end
        else
        begin
            // broken frame: a few edges, usually cut short by a tick
            count = $urandom_range(1, 10);
            repeat (count) send_item(ps2kr_pkg::OP_EDGE, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
                send_item(ps2kr_pkg::OP_TICK, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int stall_pct,
                                    input logic [15:0] limit, input int n_items,
                                    input bit squeeze, input bit pause);
        int  phase_end;
        bit  squeezed;
        bit  paused;
        write_timeout(limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        phase_end      = items_sent + n_items;
        squeezed       = 1'b0;
        paused         = 1'b0;
        while (items_sent < phase_end)
        begin
            if (squeeze && !squeezed && items_sent >= phase_end - n_items / 2)
            begin
                holdoff_request = 1'b1;
                squeezed        = 1'b1;
            end
            if (pause && !paused && items_sent >= phase_end - n_items / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            send_random_sequence();
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        op              = ps2kr_pkg::OP_EDGE;
        data_bit        = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;
        cur_timeout     = int'(ps2kr_pkg::TIMEOUT_RESET);
        quiet_cycles    = 0;
        holdoff_request = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // partial frame dropped by a tick, then a full all-ones byte
        send_item(ps2kr_pkg::OP_EDGE, 1'b0);
        send_item(ps2kr_pkg::OP_EDGE, 1'b1);
        send_item(ps2kr_pkg::OP_EDGE, 1'b1);
        send_item(ps2kr_pkg::OP_EDGE, 1'b0);
        send_item(ps2kr_pkg::OP_TICK, 1'b1);
        send_frame(8'hFF, 1'b1);
        repeat (3) send_item(ps2kr_pkg::OP_TICK, 1'b0);

        // zero timeout pulses on every tick; an edge never pulses
        write_timeout(16'h0000);
        send_item(ps2kr_pkg::OP_TICK, 1'b0);
        send_item(ps2kr_pkg::OP_TICK, 1'b1);
        send_item(ps2kr_pkg::OP_EDGE, 1'b1);
        send_item(ps2kr_pkg::OP_TICK, 1'b0);

        // lower the timeout below the count already reached
        write_timeout(16'd20);
        repeat (12) send_item(ps2kr_pkg::OP_TICK, 1'b0);
        write_timeout(16'd3);
        repeat (2) send_item(ps2kr_pkg::OP_TICK, 1'b1);

        // largest timeout: a handful of ticks, no pulse
        write_timeout(16'hFFFF);
        repeat (8) send_item(ps2kr_pkg::OP_TICK, 1'b0);

        run_random_phase(0, 0, 16'd1, 90, 1'b1, 1'b0);
        run_random_phase(51, 0, 16'($urandom_range(2, 8)), 90, 1'b0, 1'b0);
        run_random_phase(0, 51, 16'($urandom_range(9, 16)), 90, 1'b0, 1'b1);
        run_random_phase(21, 21, 16'd3, 90, 1'b0, 1'b0);

        wait_for_results();
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
